/* design/bfs_pkg.sv */
// shared codes and field widths of the breadth-first route finder
package bfs_pkg;

	localparam int IdxW = 5;
	localparam int CmdW = 2;
	localparam int StW  = 2;

	localparam logic [CmdW-1:0] CMD_ADD     = 2'd0;
	localparam logic [CmdW-1:0] CMD_CONNECT = 2'd1;
	localparam logic [CmdW-1:0] CMD_ROUTE   = 2'd2;

	localparam logic [StW-1:0] ST_OK        = 2'd0;
	localparam logic [StW-1:0] ST_LIMIT     = 2'd1;
	localparam logic [StW-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [StW-1:0] ST_NO_ROUTE  = 2'd3;

	typedef struct packed {
		logic found;
		logic [5:0] idx;
	} scan_res_t;

endpackage

/* design/bfs_ram.sv */
// generic single write, single read ram with registered read data
module bfs_ram #(
	parameter int W = 8,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* design/bfs_scan.sv */
// lowest set bit finder over the candidate neighbor mask
module bfs_scan #(
	parameter int N = 32
) (
	input  logic [N-1:0]       cand,
	output bfs_pkg::scan_res_t res
);
	import bfs_pkg::*;

	always_comb begin
		res.found = |cand;
		res.idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (cand[i]) begin
				res.idx = 6'(i);
			end
		end
	end
endmodule

/* design/bfs_route_finder.sv */
// top level: graph store, breadth-first search sequencer and result output
//
// usage
// - s_tdata carries one command item: add node, connect two nodes, or find
//   route. m_tdata carries result items, m_tlast marks the final result of a
//   command. an unused command code gives no result.
// - add, and any command that names an unknown node, gives its result in the
//   cycle after acceptance; connect gives its result from state C3, after C1 and C2.
// - a route search passes states DQ, DQ2, DQ3 and SCAN for each dequeued node,
//   staying in SCAN while neighbors are found, then W and W2 for each path node
//   on the way back, and E and E2 for each emitted node. the shared lowest-bit
//   finder and the single port of each ram set the pace of these steps.
// - s_tready is high only while the sequencer is idle and the output
//   register is free or being drained, one command is handled at a time.
// - reset clears the node count, the visited mask and the adjacency row
//   valid bits, so all rows read as empty; no clearing pass is needed.
// - when the receiver stalls, the output register holds its item and the
//   sequencer waits in place with its next result until m_tready rises.
module bfs_route_finder #(
	parameter int NODES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // cmd[1:0], node_a[6:2], node_b[11:7], zeros
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // status[1:0], node[6:2], zero
	output logic        m_tlast
);
	import bfs_pkg::*;

	localparam int NW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_C1   = 4'd1;
	localparam logic [3:0] S_C2   = 4'd2;
	localparam logic [3:0] S_C3   = 4'd3;
	localparam logic [3:0] S_R0   = 4'd4;
	localparam logic [3:0] S_DQ   = 4'd5;
	localparam logic [3:0] S_DQ2  = 4'd6;
	localparam logic [3:0] S_DQ3  = 4'd7;
	localparam logic [3:0] S_SCAN = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;
	localparam logic [3:0] S_W    = 4'd10;
	localparam logic [3:0] S_W2   = 4'd11;
	localparam logic [3:0] S_E    = 4'd12;
	localparam logic [3:0] S_E2   = 4'd13;

	logic [3:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [NODES-1:0] visited_q;
	logic [NODES-1:0] cand_q;
	logic [NODES-1:0] row_valid_q;
	logic             rv_q;
	logic [NW-1:0]    a_q, b_q, cur_q;
	logic [CW-1:0]    head_q, tail_q, depth_q;
	logic [NW-1:0]    sp_q;

	logic             ovalid_q, olast_q;
	logic [StW-1:0]   ostatus_q;
	logic [IdxW-1:0]  onode_q;

	// input fields
	logic [CmdW-1:0] in_cmd;
	logic [IdxW-1:0] in_a, in_b;
	assign in_cmd = s_tdata[1:0];
	assign in_a   = s_tdata[6:2];
	assign in_b   = s_tdata[11:7];

	logic can_push, accept, not_found;
	assign can_push  = !ovalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && can_push;
	assign accept    = s_tvalid && s_tready;
	assign not_found = (7'(in_a) >= 7'(count_q)) || (7'(in_b) >= 7'(count_q));

	// adjacency rows
	logic             adj_we;
	logic [NW-1:0]    adj_waddr, adj_raddr;
	logic [NODES-1:0] adj_wdata, adj_rdata, adj_row;

	// search queue, parent table, path stack
	logic          q_we, p_we, s_we;
	logic [NW-1:0] q_waddr, q_wdata, q_rdata;
	logic [NW-1:0] p_waddr, p_wdata, p_rdata;
	logic [NW-1:0] s_rdata;

	// lowest set candidate
	scan_res_t     scan;
	logic [NW-1:0] hit;
	assign hit = scan.idx[NW-1:0];

	bfs_scan #(.N(NODES)) u_scan (.cand(cand_q), .res(scan));

	assign adj_row = rv_q ? adj_rdata : '0;

	logic [NODES-1:0] cmask;
	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			cmask[i] = (7'(i) < 7'(count_q));
		end
	end

	always_comb begin
		unique case (state_q)
			S_C2, S_C3: adj_raddr = b_q;
			S_DQ2:      adj_raddr = q_rdata;
			default:    adj_raddr = a_q;
		endcase
		adj_we    = (state_q == S_C2) || (state_q == S_C3);
		adj_waddr = (state_q == S_C2) ? a_q : b_q;
		adj_wdata = adj_row;
		if (state_q == S_C2) begin
			adj_wdata[b_q] = 1'b1;
		end else begin
			adj_wdata[a_q] = 1'b1;
		end

		q_we    = (state_q == S_R0) || (state_q == S_SCAN && scan.found);
		q_waddr = (state_q == S_R0) ? '0 : tail_q[NW-1:0];
		q_wdata = (state_q == S_R0) ? a_q : hit;
		p_we    = q_we;
		p_waddr = (state_q == S_R0) ? a_q : hit;
		p_wdata = (state_q == S_R0) ? a_q : cur_q;
		s_we    = (state_q == S_W);
	end

	bfs_ram #(.W(NODES), .D(NODES)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_rdata)
	);
	bfs_ram #(.W(NW), .D(NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q[NW-1:0]), .rdata(q_rdata)
	);
	bfs_ram #(.W(NW), .D(NODES)) u_parent (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(cur_q), .rdata(p_rdata)
	);
	bfs_ram #(.W(NW), .D(NODES)) u_stack (
		.clk(clk), .we(s_we), .waddr(depth_q[NW-1:0]), .wdata(cur_q),
		.raddr(sp_q), .rdata(s_rdata)
	);

	// result produced this cycle
	logic            push;
	logic [StW-1:0]  p_status;
	logic [IdxW-1:0] p_node;
	logic            p_last;
	always_comb begin
		push     = 1'b0;
		p_status = ST_OK;
		p_node   = '0;
		p_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_cmd == CMD_ADD) begin
						push = 1'b1;
						if (count_q == CW'(NODES)) begin
							p_status = ST_LIMIT;
						end else begin
							p_node = IdxW'(count_q);
						end
					end else if ((in_cmd == CMD_CONNECT || in_cmd == CMD_ROUTE)
						&& not_found) begin
						push     = 1'b1;
						p_status = ST_NOT_FOUND;
					end
				end
			end
			S_C3: push = can_push;
			S_FIN: begin
				if (!visited_q[b_q]) begin
					push     = can_push;
					p_status = ST_NO_ROUTE;
				end
			end
			S_E2: begin
				push   = can_push;
				p_node = IdxW'(s_rdata);
				p_last = (sp_q == '0);
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			visited_q   <= '0;
			row_valid_q <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (push) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			if (adj_we) begin
				row_valid_q[adj_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_cmd == CMD_ADD) begin
							if (count_q != CW'(NODES)) begin
								count_q <= count_q + 1'b1;
							end
						end else if (in_cmd == CMD_CONNECT && !not_found) begin
							state_q <= S_C1;
						end else if (in_cmd == CMD_ROUTE && !not_found) begin
							state_q <= S_R0;
						end
					end
				end
				S_C1: state_q <= S_C2;
				S_C2: state_q <= S_C3;
				S_C3: begin
					if (can_push) begin
						state_q <= S_IDLE;
					end
				end
				S_R0: begin
					// only the start node is visited
					visited_q <= {{(NODES-1){1'b0}}, 1'b1} << a_q;
					state_q   <= S_DQ;
				end
				S_DQ: begin
					if (head_q == tail_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DQ2;
					end
				end
				S_DQ2: begin
					if (q_rdata == b_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DQ3;
					end
				end
				S_DQ3: state_q <= S_SCAN;
				S_SCAN: begin
					if (scan.found) begin
						visited_q[hit] <= 1'b1;
					end else begin
						state_q <= S_DQ;
					end
				end
				S_FIN: begin
					if (visited_q[b_q]) begin
						state_q <= S_W;
					end else if (can_push) begin
						state_q <= S_IDLE;
					end
				end
				S_W: begin
					if (cur_q == a_q) begin
						state_q <= S_E;
					end else begin
						state_q <= S_W2;
					end
				end
				S_W2: state_q <= S_W;
				S_E:  state_q <= S_E2;
				S_E2: begin
					if (can_push) begin
						state_q <= (sp_q == '0) ? S_IDLE : S_E;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rv_q <= row_valid_q[adj_raddr];
		if (push) begin
			ostatus_q <= p_status;
			onode_q   <= p_node;
			olast_q   <= p_last;
		end
		unique case (state_q)
			S_IDLE: begin
				a_q <= NW'(in_a);
				b_q <= NW'(in_b);
			end
			S_R0: begin
				head_q <= '0;
				tail_q <= CW'(1);
			end
			S_DQ: begin
				if (head_q != tail_q) begin
					head_q <= head_q + 1'b1;
				end
			end
			S_DQ2: cur_q <= q_rdata;
			S_DQ3: cand_q <= adj_row & ~visited_q & cmask;
			S_SCAN: begin
				if (scan.found) begin
					cand_q[hit] <= 1'b0;
					tail_q      <= tail_q + 1'b1;
				end
			end
			S_FIN: begin
				cur_q   <= b_q;
				depth_q <= '0;
			end
			S_W: begin
				depth_q <= depth_q + 1'b1;
				sp_q    <= depth_q[NW-1:0];
			end
			S_W2: cur_q <= p_rdata;
			S_E2: begin
				if (can_push && sp_q != '0) begin
					sp_q <= sp_q - 1'b1;
				end
			end
			default: cur_q <= cur_q;
		endcase
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {1'b0, onode_q, ostatus_q};
	assign m_tlast  = olast_q;
endmodule

/* verif/bfs_route_checker.sv */
// checker for the route finder: watches both streams, predicts results and compares
module bfs_route_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);
	import bfs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [StW-1:0]  status;
		logic [IdxW-1:0] node;
		logic            last;
	} route_item_t;

	logic [31:0] graph_rows [32];
	int          graph_size;
	route_item_t expected_items [$];

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic route_item_t mk(input logic [1:0] st, input int n, input logic l);
		route_item_t r;
		r.status = st;
		r.node = n[IdxW-1:0];
		r.last = l;
		return r;
	endfunction

	// breadth-first search with neighbors scanned lowest index first
	task automatic predict_route(input int src, input int dst);
		int          parent [32];
		int          fifo [32];
		int          path [$];
		logic [31:0] seen;
		int          rd, wr, cur;
		seen = 32'b1 << src;
		parent[src] = src;
		fifo[0] = src;
		rd = 0;
		wr = 1;
		while (rd < wr) begin
			cur = fifo[rd++];
			if (cur == dst) break;
			for (int i = 0; i < graph_size; i++) begin
				if (graph_rows[cur][i] && !seen[i] && wr < 32) begin
					seen[i] = 1'b1;
					parent[i] = cur;
					fifo[wr++] = i;
				end
			end
		end
		if (!seen[dst]) begin
			expected_items.push_back(mk(ST_NO_ROUTE, 0, 1'b1));
		end else begin
			cur = dst;
			path.push_front(cur);
			while (cur != src && path.size() < 32) begin
				cur = parent[cur];
				path.push_front(cur);
			end
			foreach (path[i])
				expected_items.push_back(mk(ST_OK, path[i], i == path.size() - 1));
		end
	endtask

	task automatic predict_command(input logic [15:0] d);
		logic [CmdW-1:0] op;
		int a, b;
		op = d[1:0];
		a = d[6:2];
		b = d[11:7];
		if (op == CMD_ADD) begin
			if (graph_size >= 32) begin
				expected_items.push_back(mk(ST_LIMIT, 0, 1'b1));
			end else begin
				expected_items.push_back(mk(ST_OK, graph_size, 1'b1));
				graph_size++;
			end
		end else if (op == CMD_CONNECT || op == CMD_ROUTE) begin
			if (a >= graph_size || b >= graph_size) begin
				expected_items.push_back(mk(ST_NOT_FOUND, 0, 1'b1));
			end else if (op == CMD_CONNECT) begin
				graph_rows[a][b] = 1'b1;
				graph_rows[b][a] = 1'b1;
				expected_items.push_back(mk(ST_OK, 0, 1'b1));
			end else begin
				predict_route(a, b);
			end
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		graph_size = 0;
		foreach (graph_rows[i]) graph_rows[i] = '0;
	end

	always @(posedge clk) begin
		route_item_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_items.size() == 0) begin
					report($sformatf("unexpected result %h", m_tdata));
				end else begin
					want = expected_items.pop_front();
					if (m_tdata[1:0] !== want.status)
						report($sformatf("status %0d want %0d", m_tdata[1:0], want.status));
					if (m_tdata[6:2] !== want.node)
						report($sformatf("node %0d want %0d", m_tdata[6:2], want.node));
					if (m_tlast !== want.last)
						report($sformatf("last %b want %b", m_tlast, want.last));
				end
			end
			if (s_tvalid && s_tready) predict_command(s_tdata);
		end
		pending = expected_items.size();
	end
endmodule

/* verif/tb_top.sv */
// testbench top: clock, reset, command stimulus and verdict for the route finder
module tb_top;
	import bfs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // cmd[1:0], node_a[6:2], node_b[11:7], zeros
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // status[1:0], node[6:2], zero
	logic        m_tlast;
	int          fail_count;
	int          pending;
	int          cycle_count;
	bit          sink_held;   // long receiver hold-off in progress

	bfs_route_finder uut (.*);

	bfs_route_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: worst case is far below this
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 2000000) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: a random stall before each item, or a long hold-off
	initial begin
		int w;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (sink_held) begin
				m_tready <= 1'b0;
				@(posedge clk);
			end else begin
				w = $urandom_range(0, 5);
				if (w != 0) begin
					m_tready <= 1'b0;
					repeat (w) @(posedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
				while (!m_tvalid && !sink_held) @(posedge clk);
			end
		end
	end

	// one long stall mid-run so the block backs up into its input
	initial begin
		sink_held = 1'b0;
		@(posedge arst_n);
		repeat (3000) @(posedge clk);
		sink_held = 1'b1;
		repeat (400) @(posedge clk);
		sink_held = 1'b0;
	end

	// send one item, after a random gap when gaps is set; valid held until accepted
	task automatic send(input logic [CmdW-1:0] op, input int a, input int b, input bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 5) : 0;
		if (w != 0) begin
			s_tvalid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, b[4:0], a[4:0], op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	initial begin
		int  a, b, r;
		bit  gaps;
		cycle_count = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: commands on an empty store, then build a small graph
		send(CMD_CONNECT, 0, 0, 1);
		send(CMD_ROUTE, 0, 0, 1);
		send(2'd3, 31, 31, 1);          // unused code, ignored
		repeat (6) send(CMD_ADD, 0, 0, 1);
		send(CMD_CONNECT, 0, 6, 1);     // index past the count
		send(CMD_ROUTE, 31, 0, 1);
		send(CMD_CONNECT, 0, 1, 1);
		send(CMD_CONNECT, 1, 2, 1);
		send(CMD_CONNECT, 0, 3, 1);
		send(CMD_CONNECT, 3, 2, 1);
		send(CMD_CONNECT, 4, 4, 1);     // self edge
		send(CMD_ROUTE, 0, 2, 1);
		send(CMD_ROUTE, 2, 0, 1);
		send(CMD_ROUTE, 1, 1, 1);       // same start and end
		send(CMD_ROUTE, 0, 5, 1);       // no route
		send(CMD_ROUTE, 4, 4, 1);

		// random: fill the store over time, favor routes and connects
		for (int i = 0; i < 320; i++) begin
			gaps = (i % 100) < 70;
			r = $urandom_range(0, 99);
			a = $urandom_range(0, 31);
			b = $urandom_range(0, 31);
			if (r < 12)
				send(CMD_ADD, a, b, gaps);
			else if (r < 14)
				send(2'd3, a, b, gaps);
			else if (r < 55)
				send(CMD_CONNECT, a, b, gaps);
			else
				send(CMD_ROUTE, a, b, gaps);
		end
		// long chain for deep paths once all nodes exist
		repeat (32) send(CMD_ADD, 0, 0, 1);
		for (int i = 0; i < 31; i++) send(CMD_CONNECT, i, i + 1, 1);
		send(CMD_ROUTE, 0, 31, 1);
		send(CMD_ROUTE, 31, 0, 1);
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

/* sim.f */
design/bfs_pkg.sv
design/bfs_ram.sv
design/bfs_scan.sv
design/bfs_route_finder.sv
verif/bfs_route_checker.sv
verif/tb_top.sv
